### rtl/ufr_pkg.sv
`default_nettype none

package ufr_pkg;

    localparam int FRAME_SLOTS_DEF = 4;
    localparam int FRAME_BYTES_DEF = 32;

    localparam logic [7:0] HDR_A            = 8'hAA;
    localparam logic [7:0] HDR_B            = 8'hBB;
    localparam logic [7:0] HDR_2            = 8'h83;
    localparam logic [7:0] IDLE_LIMIT_RESET = 8'd20;

    localparam logic [1:0] KIND_IDLE = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [2:0] PH_HDR1 = 3'd0;
    localparam logic [2:0] PH_HDR2 = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_SUM  = 3'd4;

    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_ACCEPT   = 2'd1;
    localparam logic [1:0] EV_MISMATCH = 2'd2;
    localparam logic [1:0] EV_REJECT   = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
        logic [1:0] read_slot;
        logic [4:0] read_index;
    } ufr_in_t;

    typedef struct packed {
        logic       timed_out;
        logic [1:0] frame_event;
        logic [1:0] write_slot;
        logic [2:0] phase;
        logic [7:0] read_data;
    } ufr_out_t;

    typedef struct packed {
        logic       timed_out;
        logic [1:0] frame_event;
        logic [1:0] write_slot;
        logic [2:0] phase;
    } ufr_status_t;

endpackage

`default_nettype wire

### rtl/ufr_ram.sv
`default_nettype none

module ufr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/ufr_deframer.sv
`default_nettype none

module ufr_deframer #(
    parameter int FRAME_SLOTS = ufr_pkg::FRAME_SLOTS_DEF,
    parameter int FRAME_BYTES = ufr_pkg::FRAME_BYTES_DEF,
    parameter int SW          = $clog2(FRAME_SLOTS),
    parameter int BW          = $clog2(FRAME_BYTES)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [7:0]           cfg_wdata,
    input  wire logic                 accept,
    input  wire ufr_pkg::ufr_in_t     item,
    output ufr_pkg::ufr_status_t      status,
    output logic                      wr_en,
    output logic [SW+BW-1:0]          wr_addr,
    output logic [7:0]                wr_data
);

    import ufr_pkg::*;

    logic [7:0]    idle_limit_reg;
    logic [2:0]    phase_reg, phase_next;
    logic [7:0]    idle_reg, idle_next;
    logic [7:0]    length_reg, length_next;
    logic [BW-1:0] count_reg, count_next;
    logic [7:0]    xor_reg, xor_next;
    logic [SW-1:0] fill_reg, fill_next;

    logic          tmo;
    logic [1:0]    ev;
    logic [2:0]    ph_cur;
    logic [7:0]    b;

    assign b = item.rx_byte;

    always_comb
    begin
        phase_next  = phase_reg;
        idle_next   = idle_reg;
        length_next = length_reg;
        count_next  = count_reg;
        xor_next    = xor_reg;
        fill_next   = fill_reg;
        tmo         = 1'b0;
        ev          = EV_NONE;
        ph_cur      = phase_reg;
        wr_en       = 1'b0;
        wr_addr     = {fill_reg, count_reg};
        wr_data     = b;
        if (item.kind != KIND_READ)
        begin
            if (idle_reg > idle_limit_reg)
            begin
                idle_next = 8'd0;
                ph_cur    = PH_HDR1;
                tmo       = 1'b1;
            end
            else
            begin
                idle_next = idle_reg + 8'd1;
            end
            phase_next = ph_cur;
            if (item.kind == KIND_BYTE)
            begin
                idle_next = 8'd0;
                case (ph_cur)
                    PH_HDR1:
                    begin
                        if (b == HDR_A || b == HDR_B)
                        begin
                            phase_next = PH_HDR2;
                        end
                    end
                    PH_HDR2:
                    begin
                        if (b == HDR_2)
                        begin
                            phase_next = PH_LEN;
                        end
                        else
                        begin
                            phase_next = PH_HDR1;
                            ev         = EV_REJECT;
                        end
                    end
                    PH_LEN:
                    begin
                        length_next = b;
                        if ({1'b0, b} >= 9'(FRAME_BYTES) || b < 8'd2)
                        begin
                            phase_next = PH_HDR1;
                            ev         = EV_REJECT;
                        end
                        else
                        begin
                            xor_next   = b;
                            count_next = '0;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        wr_en      = accept;
                        xor_next   = xor_reg ^ b;
                        count_next = count_reg + 1'b1;
                        if (9'(count_reg) + 9'd2 >= {1'b0, length_reg})
                        begin
                            phase_next = PH_SUM;
                        end
                    end
                    PH_SUM:
                    begin
                        if (xor_reg == b)
                        begin
                            fill_next = (fill_reg == SW'(FRAME_SLOTS - 1)) ? '0
                                                                           : fill_reg + 1'b1;
                            ev        = EV_ACCEPT;
                        end
                        else
                        begin
                            ev = EV_MISMATCH;
                        end
                        phase_next = PH_HDR1;
                    end
                    default:
                    begin
                        phase_next = PH_HDR1;
                    end
                endcase
            end
        end
    end

    assign status.timed_out   = tmo;
    assign status.frame_event = ev;
    assign status.write_slot  = 2'(fill_next);
    assign status.phase       = phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg <= IDLE_LIMIT_RESET;
            phase_reg      <= PH_HDR1;
            idle_reg       <= 8'd0;
            length_reg     <= 8'd0;
            count_reg      <= '0;
            xor_reg        <= 8'd0;
            fill_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                idle_limit_reg <= cfg_wdata;
            end
            if (accept)
            begin
                phase_reg  <= phase_next;
                idle_reg   <= idle_next;
                length_reg <= length_next;
                count_reg  <= count_next;
                xor_reg    <= xor_next;
                fill_reg   <= fill_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/uart_frame_receiver.sv
// UART frame receiver: one word per clock in while item_stall is low, one result word per
// input word out via the first result stage and the output stage. Frame hunt, length check,
// XOR checksum and slot pointer are registered on each accepted word; payload bytes go to a
// frame store RAM with registered read, so a read word returns its byte from the RAM output
// register. Two result stages let a new word be accepted while a finished result waits. The
// store is not cleared at reset: read only positions that a received frame has written.
`default_nettype none

module uart_frame_receiver #(
    parameter int FRAME_SLOTS = ufr_pkg::FRAME_SLOTS_DEF,
    parameter int FRAME_BYTES = ufr_pkg::FRAME_BYTES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_wdata,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire ufr_pkg::ufr_in_t  item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output ufr_pkg::ufr_out_t      result
);

    import ufr_pkg::*;

    localparam int SW = $clog2(FRAME_SLOTS);
    localparam int BW = $clog2(FRAME_BYTES);

    logic              accept;
    logic              adv1;
    ufr_status_t       status;
    logic              wr_en;
    logic [SW+BW-1:0]  wr_addr;
    logic [7:0]        wr_data;
    logic              rd_req;
    logic              rd_ok;
    logic [7:0]        ram_q;

    logic              s1_valid_reg, s1_valid_next;
    ufr_status_t       s1_status_reg;
    logic              s1_rd_ok_reg;
    logic              s2_valid_reg, s2_valid_next;
    ufr_out_t          s2_word_reg;

    assign adv1       = s1_valid_reg && (!s2_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && s2_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    assign rd_ok  = (item.kind == KIND_READ) && (int'(item.read_slot) < FRAME_SLOTS)
                    && (int'(item.read_index) < FRAME_BYTES);
    assign rd_req = accept && (item.kind == KIND_READ);

    ufr_deframer #(
        .FRAME_SLOTS (FRAME_SLOTS),
        .FRAME_BYTES (FRAME_BYTES),
        .SW          (SW),
        .BW          (BW)
    ) u_deframer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .item      (item),
        .status    (status),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    ufr_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_SLOTS * (2 ** BW)),
        .AW    (SW + BW)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_req),
        .raddr ({SW'(item.read_slot), BW'(item.read_index)}),
        .rdata (ram_q)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv1)
        begin
            s1_valid_next = 1'b0;
        end
        s2_valid_next = s2_valid_reg;
        if (adv1)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_valid_reg && !result_stall)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status;
            s1_rd_ok_reg  <= rd_ok;
        end
        if (adv1)
        begin
            s2_word_reg.timed_out   <= s1_status_reg.timed_out;
            s2_word_reg.frame_event <= s1_status_reg.frame_event;
            s2_word_reg.write_slot  <= s1_status_reg.write_slot;
            s2_word_reg.phase       <= s1_status_reg.phase;
            s2_word_reg.read_data   <= s1_rd_ok_reg ? ram_q : 8'd0;
        end
    end

    assign result_valid = s2_valid_reg;
    assign result       = s2_word_reg;

    a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted word did not reach first result stage");

    a_adv_fills_s2 : assert property (@(posedge clk) disable iff (!rst_n)
        adv1 |=> s2_valid_reg)
        else $error("advancing word did not reach output stage");

    a_tick_no_read : assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.kind != KIND_READ |=> !s1_rd_ok_reg && s1_status_reg.phase <= PH_SUM)
        else $error("tick word flagged as store read or bad phase");

endmodule

`default_nettype wire

### test/ufr_checker.sv
module ufr_checker #(
    parameter int FRAME_SLOTS = ufr_pkg::FRAME_SLOTS_DEF,
    parameter int FRAME_BYTES = ufr_pkg::FRAME_BYTES_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [7:0]                           cfg_wdata,
    input  logic                                 item_valid,
    input  logic                                 item_stall,
    input  ufr_pkg::ufr_in_t                     item,
    input  logic                                 result_valid,
    input  logic                                 result_stall,
    input  ufr_pkg::ufr_out_t                    result,
    output int                                   mismatch_count,
    output int                                   pending,
    output logic [FRAME_SLOTS*FRAME_BYTES-1:0]   written_map,
    output int                                   frames_ok,
    output int                                   checksum_errors,
    output int                                   rejects,
    output int                                   hunt_timeouts
);
    timeunit 1ns;
    timeprecision 1ps;

    import ufr_pkg::*;

    logic [7:0] idle_limit;
    logic [2:0] hunt_phase;
    logic [7:0] idle_ticks;
    logic [7:0] frame_len;
    logic [7:0] payload_cnt;
    logic [7:0] running_xor;
    int         fill_slot;
    logic [7:0] frame_store [FRAME_SLOTS*FRAME_BYTES];
    ufr_out_t   want_q [$];
    ufr_out_t   want;

    function ufr_out_t predict_word(input ufr_in_t w);
        ufr_out_t   r;
        logic [7:0] b;
        r = '0;
        b = w.rx_byte;
        if (w.kind == KIND_READ)
        begin
            if (w.read_slot < FRAME_SLOTS && w.read_index < FRAME_BYTES)
                r.read_data = frame_store[w.read_slot * FRAME_BYTES + w.read_index];
        end
        else
        begin
            if (idle_ticks > idle_limit)
            begin
                idle_ticks = '0;
                hunt_phase = PH_HDR1;
                r.timed_out = 1'b1;
                hunt_timeouts++;
            end
            else
            begin
                idle_ticks = idle_ticks + 8'd1;
            end
            if (w.kind == KIND_BYTE)
            begin
                idle_ticks = '0;
                case (hunt_phase)
                    PH_HDR1:
                    begin
                        if (b == HDR_A || b == HDR_B)
                            hunt_phase = PH_HDR2;
                    end
                    PH_HDR2:
                    begin
                        if (b == HDR_2)
                        begin
                            hunt_phase = PH_LEN;
                        end
                        else
                        begin
                            hunt_phase = PH_HDR1;
                            r.frame_event = EV_REJECT;
                        end
                    end
                    PH_LEN:
                    begin
                        frame_len = b;
                        if (b >= FRAME_BYTES || b < 2)
                        begin
                            hunt_phase = PH_HDR1;
                            r.frame_event = EV_REJECT;
                        end
                        else
                        begin
                            running_xor = b;
                            payload_cnt = '0;
                            hunt_phase = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        if (payload_cnt < FRAME_BYTES)
                        begin
                            frame_store[fill_slot * FRAME_BYTES + payload_cnt] = b;
                            written_map[fill_slot * FRAME_BYTES + payload_cnt] = 1'b1;
                        end
                        running_xor = running_xor ^ b;
                        payload_cnt = payload_cnt + 8'd1;
                        if (payload_cnt + 1 >= frame_len)
                            hunt_phase = PH_SUM;
                    end
                    PH_SUM:
                    begin
                        if (running_xor == b)
                        begin
                            fill_slot = (fill_slot + 1 >= FRAME_SLOTS) ? 0 : fill_slot + 1;
                            r.frame_event = EV_ACCEPT;
                        end
                        else
                        begin
                            r.frame_event = EV_MISMATCH;
                        end
                        hunt_phase = PH_HDR1;
                    end
                    default:
                    begin
                        hunt_phase = PH_HDR1;
                    end
                endcase
                if (r.frame_event == EV_ACCEPT)
                    frames_ok++;
                else if (r.frame_event == EV_MISMATCH)
                    checksum_errors++;
                else if (r.frame_event == EV_REJECT)
                    rejects++;
            end
        end
        r.write_slot = 2'(fill_slot);
        r.phase = hunt_phase;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] got_val);
        if (exp_val !== got_val)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, got_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit      = IDLE_LIMIT_RESET;
            hunt_phase      = PH_HDR1;
            idle_ticks      = '0;
            frame_len       = '0;
            payload_cnt     = '0;
            running_xor     = '0;
            fill_slot       = 0;
            written_map     = '0;
            want_q.delete();
            pending         = 0;
            mismatch_count  = 0;
            frames_ok       = 0;
            checksum_errors = 0;
            rejects         = 0;
            hunt_timeouts   = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (want_q.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, result);
                end
                else
                begin
                    want = want_q.pop_front();
                    check_field("timed_out", 8'(want.timed_out), 8'(result.timed_out));
                    check_field("frame_event", 8'(want.frame_event), 8'(result.frame_event));
                    check_field("write_slot", 8'(want.write_slot), 8'(result.write_slot));
                    check_field("phase", 8'(want.phase), 8'(result.phase));
                    check_field("read_data", want.read_data, result.read_data);
                end
            end
            if (item_valid && !item_stall)
                want_q.push_back(predict_word(item));
            if (cfg_we)
                idle_limit = cfg_wdata;
            pending = want_q.size();
        end
    end

endmodule

### test/tb_uart_frame_receiver.sv
module tb_uart_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    import ufr_pkg::*;

    localparam int         SLOTS       = FRAME_SLOTS_DEF;
    localparam int         BYTES       = FRAME_BYTES_DEF;
    localparam int         QUIET_LIMIT = 2000;
    localparam int         PHASE_WORDS = 275;
    localparam logic [1:0] KIND_SPARE  = 2'd3;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     cfg_we       = 1'b0;
    logic [7:0] cfg_wdata  = '0;
    logic     item_valid   = 1'b0;
    ufr_in_t  item         = '0;
    logic     result_stall = 1'b0;
    logic     item_stall;
    logic     result_valid;
    ufr_out_t result;

    int                        mismatch_count;
    int                        pending;
    logic [SLOTS*BYTES-1:0]    written_map;
    int                        frames_ok;
    int                        checksum_errors;
    int                        rejects;
    int                        hunt_timeouts;

    bit steady      = 1'b0;
    int words_sent  = 0;
    int quiet_cycles = 0;

    always #6 clk = ~clk;

    uart_frame_receiver u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    ufr_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .item_valid      (item_valid),
        .item_stall      (item_stall),
        .item            (item),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .mismatch_count  (mismatch_count),
        .pending         (pending),
        .written_map     (written_map),
        .frames_ok       (frames_ok),
        .checksum_errors (checksum_errors),
        .rejects         (rejects),
        .hunt_timeouts   (hunt_timeouts)
    );

    always @(negedge clk)
    begin
        result_stall <= !steady && ($urandom_range(99) < 17);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
            $display("uart_frame_receiver test failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called and returning at a falling edge; valid stays up until the caller drives again
    task automatic send_word(input ufr_in_t w);
        while (!steady && $urandom_range(99) < 17)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        ufr_in_t w;
        w = ufr_in_t'($urandom);
        w.kind = KIND_BYTE;
        w.rx_byte = b;
        send_word(w);
    endtask

    task automatic send_tick(input logic [1:0] kind);
        ufr_in_t w;
        w = ufr_in_t'($urandom);
        w.kind = kind;
        send_word(w);
    endtask

    // reads only store positions that some frame has already filled
    task automatic send_read();
        int      cand [$];
        int      pick;
        ufr_in_t w;
        for (int i = 0; i < SLOTS * BYTES; i++)
            if (written_map[i])
                cand.push_back(i);
        if (cand.size() == 0)
        begin
            send_tick(KIND_IDLE);
        end
        else
        begin
            pick = cand[$urandom_range(cand.size() - 1)];
            w = ufr_in_t'($urandom);
            w.kind = KIND_READ;
            w.read_slot = 2'(pick / BYTES);
            w.read_index = 5'(pick % BYTES);
            send_word(w);
        end
    endtask

    task automatic send_header();
        send_byte($urandom_range(1) ? HDR_A : HDR_B);
        send_byte(HDR_2);
    endtask

    task automatic send_frame(input int len, input bit good_sum, input bit drift);
        logic [7:0] sum;
        logic [7:0] b;
        send_header();
        send_byte(8'(len));
        sum = 8'(len);
        for (int k = 0; k < len - 1; k++)
        begin
            if (drift && $urandom_range(99) < 15)
            begin
                case ($urandom_range(2))
                    0: send_read();
                    1: send_tick(KIND_SPARE);
                    default: repeat ($urandom_range(3, 1)) send_tick(KIND_IDLE);
                endcase
            end
            b = 8'($urandom);
            send_byte(b);
            sum = sum ^ b;
        end
        if (!good_sum)
            sum = sum ^ 8'($urandom_range(255, 1));
        send_byte(sum);
    endtask

    task automatic write_idle_limit(input logic [7:0] v);
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [7:0] limits [5];
        logic [7:0] b;
        ufr_in_t    w;
        int         sel;
        int         len;

        limits[0] = 8'd0;
        limits[1] = 8'd255;
        limits[2] = 8'($urandom_range(254, 1));
        limits[3] = 8'd3;
        limits[4] = 8'd21;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: idle kinds, stray bytes, bad header, bad lengths, good and bad frames, a store read
        send_tick(KIND_IDLE);
        send_tick(KIND_SPARE);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HDR_A);
        send_byte(8'h00);
        send_byte(HDR_B);
        send_byte(HDR_2);
        send_byte(8'd1);
        send_byte(HDR_A);
        send_byte(HDR_2);
        send_byte(8'd32);
        send_byte(HDR_B);
        send_byte(HDR_2);
        send_byte(8'd0);
        send_frame(2, 1'b1, 1'b0);
        send_read();
        send_frame(3, 1'b0, 1'b0);

        for (int ph = 0; ph < 5; ph++)
        begin
            write_idle_limit(limits[ph]);
            steady = (ph == 2);
            while (words_sent < 25 + (ph + 1) * PHASE_WORDS)
            begin
                sel = $urandom_range(99);
                if (sel < 65)
                begin
                    case ($urandom_range(9))
                        0: len = 2;
                        1: len = BYTES - 1;
                        default: len = $urandom_range(BYTES - 1, 2);
                    endcase
                    send_frame(len, $urandom_range(99) < 85, $urandom_range(3) == 0);
                end
                else if (sel < 75)
                begin
                    repeat ($urandom_range(6, 1))
                    begin
                        w = ufr_in_t'($urandom);
                        if (w.kind == KIND_READ)
                            send_read();
                        else
                            send_word(w);
                    end
                end
                else if (sel < 87)
                begin
                    case ($urandom_range(3))
                        0:
                        begin
                            send_byte($urandom_range(1) ? HDR_A : HDR_B);
                            b = 8'($urandom);
                            if (b == HDR_2)
                                b = b ^ 8'h01;
                            send_byte(b);
                        end
                        1:
                        begin
                            send_header();
                            case ($urandom_range(2))
                                0: send_byte(8'd0);
                                1: send_byte(8'd1);
                                default: send_byte(8'($urandom_range(255, BYTES)));
                            endcase
                        end
                        2:
                        begin
                            len = $urandom_range(BYTES - 1, 2);
                            send_header();
                            send_byte(8'(len));
                            repeat ($urandom_range(len - 2)) send_byte(8'($urandom));
                        end
                        default:
                        begin
                            send_byte($urandom_range(1) ? HDR_A : HDR_B);
                            send_tick($urandom_range(1) ? KIND_IDLE : KIND_SPARE);
                        end
                    endcase
                end
                else if (sel < 95)
                begin
                    repeat ($urandom_range(40))
                        send_tick($urandom_range(3) ? KIND_IDLE : KIND_SPARE);
                end
                else
                begin
                    repeat ($urandom_range(4, 1)) send_read();
                end
            end
        end

        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("%0d words over 5 idle-limit settings: %0d frames accepted, %0d checksum errors",
                 words_sent, frames_ok, checksum_errors);
        $display("%0d header or length rejects, %0d hunt timeouts", rejects, hunt_timeouts);
        if (mismatch_count == 0 && pending == 0)
            $display("uart_frame_receiver test passed");
        else
            $display("uart_frame_receiver test failed");
        $finish;
    end

endmodule

### sim.f
rtl/ufr_pkg.sv
rtl/ufr_ram.sv
rtl/ufr_deframer.sv
rtl/uart_frame_receiver.sv
test/ufr_checker.sv
test/tb_uart_frame_receiver.sv
